>>> sv/tgarle_pkg.sv
// Package: shared types and constants of the TGA RLE pixel decoder.
`default_nettype none

package tgarle_pkg;

	// Header byte positions within the 18-byte TGA header.
	localparam logic [4:0] HdrIdLen    = 5'd0;
	localparam logic [4:0] HdrType     = 5'd2;
	localparam logic [4:0] HdrWidthLo  = 5'd12;
	localparam logic [4:0] HdrWidthHi  = 5'd13;
	localparam logic [4:0] HdrHeightLo = 5'd14;
	localparam logic [4:0] HdrHeightHi = 5'd15;
	localparam logic [4:0] HdrDepth    = 5'd16;
	localparam logic [4:0] HdrLast     = 5'd17;

	localparam logic [7:0] TypeRaw   = 8'd2;
	localparam logic [7:0] TypeRle   = 8'd10;
	localparam logic [7:0] DepthRgb  = 8'd24;
	localparam logic [7:0] DepthRgba = 8'd32;

	localparam logic [7:0] AlphaFillReset = 8'd255;
	localparam logic [7:0] MaxRepeat      = 8'd128;

	typedef enum logic [1:0] {
		KIND_PIXEL     = 2'd0,
		KIND_HEADER    = 2'd1,
		KIND_BAD_TYPE  = 2'd2,
		KIND_BAD_DEPTH = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

>>> sv/tgarle_if.sv
// Interfaces: the byte input channel and the result output channel.
`default_nettype none

interface tgarle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tgarle_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_count;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        last;

	modport source (output valid, output kind, output red, output green, output blue,
		output alpha, output repeat_count, output image_width, output image_height,
		output last, input ready);
	modport sink (input valid, input kind, input red, input green, input blue,
		input alpha, input repeat_count, input image_width, input image_height,
		input last, output ready);
endinterface

`default_nettype wire

>>> sv/tga_rle_pixel_decoder.sv
// Top level: TGA truecolor (raw and RLE) byte stream to RGBA pixel run decoder.
//
// The block takes the bytes of a TGA file, one per transfer on in_ch, with
// first_byte set on header byte 0 of each file. A first_byte transfer always
// starts a new header, dropping whatever file was in progress. Bytes with
// first_byte clear while no file is open are dropped without a result.
// Each byte yields at most one result on out_ch: kind 1 with the image size
// at the last header byte, kind 2 or 3 (with last set) for an unsupported
// image type or depth, and kind 0 for a pixel run. Raw pixels come out with a
// repeat count of 1; a run packet comes out once with its count, clipped to
// the pixels still owed for width times height. last marks the final run.
// A byte is taken into the input register, and its result passes on into
// the output register, from which it is shown. Throughput is one byte per
// cycle while out_ch does not stall: the decode of a byte is a single pass
// of header/packet logic and one 16x16 multiply (width times height)
// between the two registers.
// When out_ch stalls, the output register holds its result and the input
// register keeps one more byte; in_ch.ready drops only when both are full.
// Reset clears all decoder state, empties both registers and loads alpha_fill
// with 255. cfg_we writes alpha_fill, used as the alpha of 24-bit images.
`default_nettype none

module tga_rle_pixel_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tgarle_in_if.sink       in_ch,
	tgarle_out_if.source    out_ch,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_IDSKIP,
		PH_PKTHDR,
		PH_PIXEL
	} phase_t;

	// Input register.
	logic       in_valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;

	// Output register.
	logic                 out_valid_q;
	tgarle_pkg::result_t  res_q;

	// Decoder state.
	phase_t      phase_q,    phase_n;
	logic [4:0]  hdr_idx_q,  hdr_idx_n;
	logic [7:0]  id_left_q,  id_left_n;
	logic        compr_q,    compr_n;
	logic [2:0]  bpp_q,      bpp_n;
	logic [15:0] width_q,    width_n;
	logic [15:0] height_q,   height_n;
	logic [31:0] pix_left_q, pix_left_n;
	logic [7:0]  pkt_left_q, pkt_left_n;
	logic        pkt_run_q,  pkt_run_n;
	logic [1:0]  bip_q,      bip_n;
	logic [23:0] color_q,    color_n;
	logic [7:0]  alpha_fill_q;

	tgarle_pkg::result_t res_n;
	logic                emit_n;

	logic        advance;
	logic        fire;
	logic [31:0] area;
	logic [23:0] color_w;
	logic [7:0]  reps;
	logic [4:0]  idx;

	// The input register moves on whenever the output register is free or
	// is being emptied in this cycle.
	assign advance     = !out_valid_q || out_ch.ready;
	assign fire        = in_valid_s1 && advance;
	assign in_ch.ready = !in_valid_s1 || advance;

	assign area = {16'd0, width_q} * {16'd0, height_q};

	always_comb begin
		phase_n    = phase_q;
		hdr_idx_n  = hdr_idx_q;
		id_left_n  = id_left_q;
		compr_n    = compr_q;
		bpp_n      = bpp_q;
		width_n    = width_q;
		height_n   = height_q;
		pix_left_n = pix_left_q;
		pkt_left_n = pkt_left_q;
		pkt_run_n  = pkt_run_q;
		bip_n      = bip_q;
		color_n    = color_q;
		res_n      = '0;
		emit_n     = 1'b0;
		color_w    = color_q;
		reps       = 8'd1;
		idx        = hdr_idx_q;

		// A first byte wipes the file state and is then parsed as header byte 0.
		if (first_s1) begin
			phase_n    = PH_HEADER;
			hdr_idx_n  = '0;
			id_left_n  = '0;
			compr_n    = 1'b0;
			bpp_n      = '0;
			width_n    = '0;
			height_n   = '0;
			pix_left_n = '0;
			pkt_left_n = '0;
			pkt_run_n  = 1'b0;
			bip_n      = '0;
			color_n    = '0;
			idx        = '0;
		end

		unique case (phase_n)
			PH_HEADER: begin
				hdr_idx_n = idx + 5'd1;
				if (idx == tgarle_pkg::HdrIdLen) begin
					id_left_n = data_s1;
				end
				if (idx == tgarle_pkg::HdrType) begin
					if (data_s1 != tgarle_pkg::TypeRaw && data_s1 != tgarle_pkg::TypeRle) begin
						res_n.kind = tgarle_pkg::KIND_BAD_TYPE;
						res_n.last = 1'b1;
						emit_n     = 1'b1;
						phase_n    = PH_IDLE;
					end
					compr_n = (data_s1 == tgarle_pkg::TypeRle);
				end
				if (idx == tgarle_pkg::HdrWidthLo)  width_n[7:0]   = data_s1;
				if (idx == tgarle_pkg::HdrWidthHi)  width_n[15:8]  = data_s1;
				if (idx == tgarle_pkg::HdrHeightLo) height_n[7:0]  = data_s1;
				if (idx == tgarle_pkg::HdrHeightHi) height_n[15:8] = data_s1;
				if (idx == tgarle_pkg::HdrDepth) begin
					if (data_s1 != tgarle_pkg::DepthRgb && data_s1 != tgarle_pkg::DepthRgba) begin
						res_n.kind = tgarle_pkg::KIND_BAD_DEPTH;
						res_n.last = 1'b1;
						emit_n     = 1'b1;
						phase_n    = PH_IDLE;
					end
					bpp_n = data_s1[5:3];
				end
				if (idx == tgarle_pkg::HdrLast) begin
					// Width and height are complete by now, so the registered
					// values feed the pixel count.
					pix_left_n         = area;
					res_n.kind         = tgarle_pkg::KIND_HEADER;
					res_n.image_width  = width_q;
					res_n.image_height = height_q;
					emit_n             = 1'b1;
					if (area == 32'd0) begin
						res_n.last = 1'b1;
						phase_n    = PH_IDLE;
					end else if (id_left_q != 8'd0) begin
						phase_n = PH_IDSKIP;
					end else begin
						bip_n   = '0;
						color_n = '0;
						phase_n = compr_q ? PH_PKTHDR : PH_PIXEL;
					end
				end
			end
			PH_IDSKIP: begin
				id_left_n = id_left_q - 8'd1;
				if (id_left_n == 8'd0) begin
					bip_n   = '0;
					color_n = '0;
					phase_n = compr_q ? PH_PKTHDR : PH_PIXEL;
				end
			end
			PH_PKTHDR: begin
				// Both packet kinds carry a count of the low seven bits plus one.
				pkt_run_n  = data_s1[7];
				pkt_left_n = {1'b0, data_s1[6:0]} + 8'd1;
				bip_n      = '0;
				color_n    = '0;
				phase_n    = PH_PIXEL;
			end
			PH_PIXEL: begin
				unique case (bip_q)
					2'd0:    color_w[7:0]   = data_s1;
					2'd1:    color_w[15:8]  = data_s1;
					2'd2:    color_w[23:16] = data_s1;
					default: color_w        = color_q;
				endcase
				if ({1'b0, bip_q} + 3'd1 < bpp_q) begin
					bip_n   = bip_q + 2'd1;
					color_n = color_w;
				end else begin
					// A run is clipped to the pixels the image still owes.
					if (compr_q && pkt_run_q) begin
						reps = ({24'd0, pkt_left_q} < pix_left_q) ? pkt_left_q : pix_left_q[7:0];
					end
					pix_left_n         = pix_left_q - {24'd0, reps};
					res_n.kind         = tgarle_pkg::KIND_PIXEL;
					res_n.red          = color_w[23:16];
					res_n.green        = color_w[15:8];
					res_n.blue         = color_w[7:0];
					res_n.alpha        = (bpp_q == 3'd4) ? data_s1 : alpha_fill_q;
					res_n.repeat_count = reps;
					emit_n             = 1'b1;
					bip_n              = '0;
					color_n            = '0;
					if (pix_left_n == 32'd0) begin
						res_n.last = 1'b1;
						phase_n    = PH_IDLE;
					end else if (compr_q) begin
						if (pkt_run_q) begin
							phase_n = PH_PKTHDR;
						end else begin
							pkt_left_n = pkt_left_q - 8'd1;
							if (pkt_left_n == 8'd0) begin
								phase_n = PH_PKTHDR;
							end
						end
					end
				end
			end
			default: begin
				// Idle: bytes outside a file are dropped.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
			phase_q      <= PH_IDLE;
			hdr_idx_q    <= '0;
			id_left_q    <= '0;
			compr_q      <= 1'b0;
			bpp_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			pix_left_q   <= '0;
			pkt_left_q   <= '0;
			pkt_run_q    <= 1'b0;
			bip_q        <= '0;
			color_q      <= '0;
			alpha_fill_q <= tgarle_pkg::AlphaFillReset;
		end else begin
			if (cfg_we) begin
				alpha_fill_q <= cfg_wdata;
			end
			if (in_ch.ready) begin
				in_valid_s1 <= in_ch.valid;
			end
			if (fire) begin
				phase_q    <= phase_n;
				hdr_idx_q  <= hdr_idx_n;
				id_left_q  <= id_left_n;
				compr_q    <= compr_n;
				bpp_q      <= bpp_n;
				width_q    <= width_n;
				height_q   <= height_n;
				pix_left_q <= pix_left_n;
				pkt_left_q <= pkt_left_n;
				pkt_run_q  <= pkt_run_n;
				bip_q      <= bip_n;
				color_q    <= color_n;
			end
			if (fire && emit_n) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the input byte and the pending result.
	always_ff @(posedge clk) begin
		if (in_ch.ready) begin
			data_s1  <= in_ch.data_byte;
			first_s1 <= in_ch.first_byte;
		end
		if (fire && emit_n) begin
			res_q <= res_n;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = res_q.kind;
	assign out_ch.red          = res_q.red;
	assign out_ch.green        = res_q.green;
	assign out_ch.blue         = res_q.blue;
	assign out_ch.alpha        = res_q.alpha;
	assign out_ch.repeat_count = res_q.repeat_count;
	assign out_ch.image_width  = res_q.image_width;
	assign out_ch.image_height = res_q.image_height;
	assign out_ch.last         = res_q.last;

endmodule

`default_nettype wire

>>> sv/tgarle_checker.sv
// Checker: port-level assertions on the TGA RLE pixel decoder, and its bind.
`default_nettype none

module tgarle_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue,
	input wire logic [7:0]  alpha,
	input wire logic [7:0]  repeat_count,
	input wire logic [15:0] image_width,
	input wire logic [15:0] image_height,
	input wire logic        last
);

	// A stalled result keeps its whole payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({kind, red, green, blue, alpha,
			repeat_count, image_width, image_height, last}))
		else $error("result changed while stalled");

	// Header errors always close the file.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tgarle_pkg::KIND_BAD_TYPE || kind == tgarle_pkg::KIND_BAD_DEPTH)
		|-> last)
		else $error("error result without last");

	// A pixel run covers 1 to 128 pixels and carries no image size.
	a_pixel_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tgarle_pkg::KIND_PIXEL
		|-> repeat_count != 8'd0 && repeat_count <= tgarle_pkg::MaxRepeat
			&& image_width == 16'd0 && image_height == 16'd0)
		else $error("bad pixel run fields");

	// Non-pixel results carry no color and no repeat count.
	a_info_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != tgarle_pkg::KIND_PIXEL
		|-> red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0
			&& repeat_count == 8'd0)
		else $error("color fields set on a non-pixel result");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.kind         (out_ch.kind),
	.red          (out_ch.red),
	.green        (out_ch.green),
	.blue         (out_ch.blue),
	.alpha        (out_ch.alpha),
	.repeat_count (out_ch.repeat_count),
	.image_width  (out_ch.image_width),
	.image_height (out_ch.image_height),
	.last         (out_ch.last)
);

`default_nettype wire
